// ===== src/itop_pkg.sv =====
package itop_pkg;

  typedef enum logic [2:0] {
    CODE_OPEN = 3'd0,
    CODE_ADD  = 3'd1,
    CODE_SUB  = 3'd2,
    CODE_MUL  = 3'd3,
    CODE_DIV  = 3'd4
  } op_code_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_UNMATCH  = 2'd2
  } err_code_t;

  typedef enum logic [1:0] {
    MODE_FLUSH = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_OP    = 2'd2
  } pop_mode_t;

  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_DIV   = 8'h2F;

  function automatic logic [7:0] char_of(input logic [2:0] code);
    logic [7:0] ch;
    case (code)
      CODE_OPEN: ch = CH_OPEN;
      CODE_ADD:  ch = CH_ADD;
      CODE_SUB:  ch = CH_SUB;
      CODE_MUL:  ch = CH_MUL;
      CODE_DIV:  ch = CH_DIV;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic prio_high(input logic [2:0] code);
    return (code == CODE_MUL) || (code == CODE_DIV);
  endfunction

endpackage

// ===== src/itop_stack.sv =====
module itop_stack #(
  parameter int STACK_DEPTH = 16,
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [2:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [2:0]    rd_data
);

  logic [2:0] mem [STACK_DEPTH];
  logic [2:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/infix_to_postfix_converter_top.sv =====
// Operand characters: out_tvalid rises the cycle after acceptance; one item per cycle
// while idle and not stalled. Operators and ')' on a non-empty stack: each stack entry
// examined is read (S_RD), then evaluated (S_EV), as the stack memory read is registered.
// End item: each stacked entry is read and evaluated, then the final item is sent.
// Reset (rst_n low, synchronous): stack empty, error cleared, no item pending.
module infix_to_postfix_converter_top
  import itop_pkg::*;
#(
  parameter int STACK_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_in
  input  logic       in_tuser,   // end_of_expr
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // char_out
  output logic [2:0] out_tuser,  // has_char, error_code[2:1]
  output logic       out_tlast
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_EV   = 4'b0100,
    S_END  = 4'b1000
  } state_t;

  state_t      st_r, st_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [1:0]  err_r, err_nxt;
  pop_mode_t   mode_r, mode_nxt;
  logic [2:0]  code_r, code_nxt;
  logic        pend_r, pend_nxt;
  logic [7:0]  pend_ch_r, pend_ch_nxt;

  logic        ov_r, ov_nxt;
  logic [7:0]  och_r, och_nxt;
  logic        ohas_r, ohas_nxt;
  logic        olast_r, olast_nxt;
  logic [1:0]  oerr_r, oerr_nxt;

  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [2:0]    wr_data, top;
  logic [CW-1:0] cnt_dec;
  logic          out_free, push_ok, in_acc, is_op;
  logic [2:0]    in_code;

  itop_stack #(.STACK_DEPTH(STACK_DEPTH)) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (top)
  );

  assign out_free  = !ov_r || out_tready;
  assign in_tready = (st_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cnt_dec   = count_r - CW'(1);
  assign push_ok   = count_r < DEPTH_C;
  assign rd_addr   = cnt_dec[AW-1:0];
  assign rd_en     = (st_r == S_RD);

  always_comb begin
    is_op   = 1'b1;
    in_code = CODE_OPEN;
    case (in_tdata)
      CH_ADD:  in_code = CODE_ADD;
      CH_SUB:  in_code = CODE_SUB;
      CH_MUL:  in_code = CODE_MUL;
      CH_DIV:  in_code = CODE_DIV;
      default: is_op = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt      = st_r;
    count_nxt   = count_r;
    err_nxt     = err_r;
    mode_nxt    = mode_r;
    code_nxt    = code_r;
    pend_nxt    = pend_r;
    pend_ch_nxt = pend_ch_r;
    ov_nxt      = ov_r && !out_tready;
    och_nxt     = och_r;
    ohas_nxt    = ohas_r;
    olast_nxt   = olast_r;
    oerr_nxt    = oerr_r;
    wr_en       = 1'b0;
    wr_addr     = count_r[AW-1:0];
    wr_data     = code_r;

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            mode_nxt = MODE_FLUSH;
            st_nxt   = (count_r == '0) ? S_END : S_RD;
          end else if (in_tdata == CH_OPEN) begin
            if (push_ok) begin
              wr_en     = 1'b1;
              wr_data   = CODE_OPEN;
              count_nxt = count_r + CW'(1);
            end else if (err_r == ERR_NONE) begin
              err_nxt = ERR_OVERFLOW;
            end
          end else if (in_tdata == CH_CLOSE) begin
            mode_nxt = MODE_CLOSE;
            if (count_r == '0) begin
              if (err_r == ERR_NONE) err_nxt = ERR_UNMATCH;
            end else begin
              st_nxt = S_RD;
            end
          end else if (is_op) begin
            mode_nxt = MODE_OP;
            code_nxt = in_code;
            if (count_r == '0) begin
              wr_en     = 1'b1;
              wr_data   = in_code;
              count_nxt = count_r + CW'(1);
            end else begin
              st_nxt = S_RD;
            end
          end else begin
            ov_nxt    = 1'b1;
            och_nxt   = in_tdata;
            ohas_nxt  = 1'b1;
            olast_nxt = 1'b0;
            oerr_nxt  = err_r;
          end
        end
      end
      S_RD: begin
        st_nxt = S_EV;
      end
      S_EV: begin
        case (mode_r)
          MODE_FLUSH: begin
            if (top == CODE_OPEN || !pend_r || out_free) begin
              if (top != CODE_OPEN) begin
                if (pend_r) begin
                  ov_nxt    = 1'b1;
                  och_nxt   = pend_ch_r;
                  ohas_nxt  = 1'b1;
                  olast_nxt = 1'b0;
                  oerr_nxt  = err_r;
                end
                pend_nxt    = 1'b1;
                pend_ch_nxt = char_of(top);
              end
              count_nxt = cnt_dec;
              st_nxt    = (cnt_dec == '0) ? S_END : S_RD;
            end
          end
          MODE_CLOSE: begin
            if (top == CODE_OPEN) begin
              count_nxt = cnt_dec;
              st_nxt    = S_IDLE;
            end else if (out_free) begin
              ov_nxt    = 1'b1;
              och_nxt   = char_of(top);
              ohas_nxt  = 1'b1;
              olast_nxt = 1'b0;
              oerr_nxt  = err_r;
              count_nxt = cnt_dec;
              if (cnt_dec == '0) begin
                if (err_r == ERR_NONE) err_nxt = ERR_UNMATCH;
                st_nxt = S_IDLE;
              end else begin
                st_nxt = S_RD;
              end
            end
          end
          default: begin
            if (top != CODE_OPEN && (prio_high(top) || !prio_high(code_r))) begin
              if (out_free) begin
                ov_nxt    = 1'b1;
                och_nxt   = char_of(top);
                ohas_nxt  = 1'b1;
                olast_nxt = 1'b0;
                oerr_nxt  = err_r;
                if (cnt_dec == '0) begin
                  wr_en   = 1'b1;
                  wr_addr = cnt_dec[AW-1:0];
                  st_nxt  = S_IDLE;
                end else begin
                  count_nxt = cnt_dec;
                  st_nxt    = S_RD;
                end
              end
            end else begin
              if (push_ok) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end else if (err_r == ERR_NONE) begin
                err_nxt = ERR_OVERFLOW;
              end
              st_nxt = S_IDLE;
            end
          end
        endcase
      end
      S_END: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          och_nxt   = pend_r ? pend_ch_r : 8'h00;
          ohas_nxt  = pend_r;
          olast_nxt = 1'b1;
          oerr_nxt  = err_r;
          pend_nxt  = 1'b0;
          err_nxt   = ERR_NONE;
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      count_r <= '0;
      err_r   <= ERR_NONE;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      mode_r  <= MODE_FLUSH;
    end else begin
      st_r    <= st_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
      mode_r  <= mode_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r    <= code_nxt;
    pend_ch_r <= pend_ch_nxt;
    och_r     <= och_nxt;
    ohas_r    <= ohas_nxt;
    olast_r   <= olast_nxt;
    oerr_r    <= oerr_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = och_r;
  assign out_tuser  = {oerr_r, ohas_r};
  assign out_tlast  = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("stack count beyond depth");

  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    err_r != 2'd3) else $error("invalid sticky error");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_END && out_free) |=> (err_r == ERR_NONE && out_tlast && count_r == '0))
    else $error("end item did not close the expression");

  a_empty_item: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tdata == 8'h00))
    else $error("empty item not marked last");

  a_pop_reads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RD) |-> (count_r != '0)) else $error("read of empty stack");

endmodule
